// File: hdl/wsht_pkg.sv
// Shared types and constants for the window stack hit test block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wsht_pkg;

	// Default sizing, handed down from the top level parameters.
	localparam int MAX_WINDOWS_DEF = 16;
	localparam int COORD_BITS_DEF  = 12;

	// Fixed field widths at the ports.
	localparam int PORT_COORD_W = 12;
	localparam int ID_W         = 5;

	// Request kinds carried on the mode field.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_CLICK = 1'b1;

	typedef struct packed {
		logic load;
		logic click;
		logic scan_step;
		logic take_hit;
		logic move_step;
		logic move_final;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic hit;
		logic scan_miss;
		logic move_done;
	} status_t;

endpackage

`default_nettype wire

// File: hdl/window_stack_hit_test_top.sv
// Top level of the window stack hit test block.
// Instantiates wsht_ctrl and wsht_datapath; uses wsht_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a stack of up to MAX_WINDOWS rectangles in a table with one read
// and one write port and answers click requests with the id of the topmost
// rectangle that contains the point, bounds inclusive, rotating that
// rectangle to the top while the others keep their order. A load request
// appends a rectangle and returns nothing; loads past capacity are dropped.
// A click request returns one result: hit with its id, or hit low and id
// zero. A click on an empty stack skips the scan. The table memory moves
// one entry per cycle in both the scan, which reads from the top down to
// the hit (all entries on a miss), and the rotation, which shifts the
// entries above the hit down. One request is handled at a time and the
// input stays stalled until the result is handed to the output register,
// so an earlier result still held there adds its wait. A finished result
// waits in the output register while the next request is taken.
module window_stack_hit_test_top #(
	parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
	parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] left_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] bottom_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] right_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] top_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] point_x,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] point_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [wsht_pkg::ID_W-1:0]         window_id
);
	import wsht_pkg::*;

	cmd_t    cmd;
	status_t status;

	wsht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	wsht_datapath #(
		.MAX_WINDOWS (MAX_WINDOWS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.left_edge   (left_edge),
		.bottom_edge (bottom_edge),
		.right_edge  (right_edge),
		.top_edge    (top_edge),
		.point_x     (point_x),
		.point_y     (point_y),
		.hit         (hit),
		.window_id   (window_id)
	);

endmodule

`default_nettype wire

// File: hdl/wsht_ctrl.sv
// Controller state machine for the window stack hit test block.
// Sequences load, scan, rotate and result delivery; uses wsht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsht_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	output logic             out_valid,
	input  logic             out_stall,
	input  wsht_pkg::status_t status,
	output wsht_pkg::cmd_t    cmd
);
	import wsht_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MOVE = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.click = 1'b1;
						state_d   = status.empty ? ST_OUT : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				priority if (status.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = ST_MOVE;
				end else if (status.scan_miss) begin
					state_d = ST_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_MOVE: begin
				if (status.move_done) begin
					cmd.move_final = 1'b1;
					state_d        = ST_OUT;
				end else begin
					cmd.move_step = 1'b1;
				end
			end
			ST_OUT: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/wsht_datapath.sv
// Datapath for the window stack hit test block: the window table memory,
// the scan and rotate address counters, the containment compare and result
// registers. Driven by wsht_ctrl through wsht_pkg command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module wsht_datapath #(
	parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
	parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wsht_pkg::cmd_t                    cmd,
	output wsht_pkg::status_t                 status,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] left_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] bottom_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] right_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] top_edge,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] point_x,
	input  logic [wsht_pkg::PORT_COORD_W-1:0] point_y,
	output logic                              hit,
	output logic [wsht_pkg::ID_W-1:0]         window_id
);
	import wsht_pkg::*;

	localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t          left;
		coord_t          bottom;
		coord_t          right;
		coord_t          top;
		logic [ID_W-1:0] id;
	} entry_t;

	entry_t           mem [MAX_WINDOWS];
	entry_t           rd_s1;
	entry_t           moved_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] k_q;
	logic [IDX_W-1:0] j_q;
	logic             more_q;
	coord_t           px_q;
	coord_t           py_q;
	logic             res_hit_q;
	logic [ID_W-1:0]  res_id_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic             full;
	logic             holds;

	assign full   = (cnt_q == CNT_W'(MAX_WINDOWS));
	assign cnt_m1 = cnt_q - 1'b1;
	assign holds  = (px_q >= rd_s1.left) && (px_q <= rd_s1.right) &&
	                (py_q >= rd_s1.bottom) && (py_q <= rd_s1.top);

	assign status.empty     = (cnt_q == '0);
	assign status.hit       = rd_vld_s1 && holds;
	assign status.scan_miss = rd_vld_s1 && !holds && (rd_idx_s1 == '0);
	assign status.move_done = (k_q == cnt_q) && !rd_vld_s1;

	// One write port shared by appends, the rotate shift and the final
	// placement of the hit entry on top; these never overlap in time.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd_s1;
		if (cmd.load && !full) begin
			we          = 1'b1;
			waddr       = cnt_q[IDX_W-1:0];
			wdata.left   = COORD_BITS'(left_edge);
			wdata.bottom = COORD_BITS'(bottom_edge);
			wdata.right  = COORD_BITS'(right_edge);
			wdata.top    = COORD_BITS'(top_edge);
			wdata.id     = ID_W'(32'(cnt_q) + 32'd1);
		end else if (cmd.move_step && rd_vld_s1) begin
			we    = 1'b1;
			waddr = rd_idx_s1 - 1'b1;
			wdata = rd_s1;
		end else if (cmd.move_final) begin
			we    = 1'b1;
			waddr = cnt_m1[IDX_W-1:0];
			wdata = moved_q;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = j_q;
		if (cmd.scan_step && more_q) begin
			re    = 1'b1;
			raddr = j_q;
		end else if (cmd.move_step && (k_q != cnt_q)) begin
			re    = 1'b1;
			raddr = k_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			k_q       <= '0;
			j_q       <= '0;
			more_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			if (cmd.load && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.click) begin
				j_q       <= cnt_m1[IDX_W-1:0];
				more_q    <= (cnt_q != '0);
				rd_vld_s1 <= 1'b0;
			end
			// Scan walks down from the top entry, one read per cycle.
			if (cmd.scan_step) begin
				if (more_q) begin
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= j_q;
					if (j_q == '0) begin
						more_q <= 1'b0;
					end else begin
						j_q <= j_q - 1'b1;
					end
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end
			if (cmd.take_hit) begin
				k_q       <= CNT_W'(rd_idx_s1) + 1'b1;
				rd_vld_s1 <= 1'b0;
			end
			// Rotate: read entry k and write it one slot lower in the next cycle.
			if (cmd.move_step) begin
				if (k_q != cnt_q) begin
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= k_q[IDX_W-1:0];
					k_q       <= k_q + 1'b1;
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.click) begin
			px_q      <= COORD_BITS'(point_x);
			py_q      <= COORD_BITS'(point_y);
			res_hit_q <= 1'b0;
			res_id_q  <= '0;
		end
		if (cmd.take_hit) begin
			moved_q   <= rd_s1;
			res_hit_q <= 1'b1;
			res_id_q  <= rd_s1.id;
		end
		if (cmd.out_load) begin
			hit       <= res_hit_q;
			window_id <= res_id_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/wsht_checker.sv
// Port-level assertions for window_stack_hit_test_top, with the bind that
// attaches them. Uses wsht_pkg for the request kinds and id width.
`timescale 1ns / 1ps
`default_nettype none

module wsht_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      mode,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      hit,
	input logic [wsht_pkg::ID_W-1:0] window_id
);
	import wsht_pkg::*;

	// A held result keeps its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(window_id))
		else $error("result changed while stalled");

	// A miss always reports id zero.
	a_miss_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> window_id == '0)
		else $error("miss with nonzero window id");

	// A load finishes in the cycle it is taken, so the next request is open.
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_LOAD |=> !in_stall)
		else $error("load request blocked the input");

	// A click always occupies the block for at least the next cycle.
	a_click_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_CLICK |=> in_stall)
		else $error("click request did not occupy the block");

endmodule

bind window_stack_hit_test_top wsht_checker u_wsht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.window_id (window_id)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for window_stack_hit_test_top: a directed table, then random clicks and loads.
// Depends on wsht_pkg and the RTL under hdl/; an internal stack predictor supplies expectations.
`timescale 1ns / 1ps

module tb;
	import wsht_pkg::*;

	localparam int NWIN          = MAX_WINDOWS_DEF;
	localparam int CW            = PORT_COORD_W;
	localparam int COORD_MAX     = (1 << CW) - 1;
	localparam int RANDOM_CLICKS = 2000;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 2 * NWIN + 8;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [CW-1:0]   left;
		logic [CW-1:0]   bottom;
		logic [CW-1:0]   right;
		logic [CW-1:0]   top;
		logic [ID_W-1:0] id;
	} win_t;

	typedef struct {
		logic          mode;
		logic [CW-1:0] left;
		logic [CW-1:0] bottom;
		logic [CW-1:0] right;
		logic [CW-1:0] top;
		logic [CW-1:0] px;
		logic [CW-1:0] py;
	} wreq_t;

	typedef struct {
		logic            hit;
		logic [ID_W-1:0] id;
	} click_res_t;

	typedef struct {
		wreq_t      req;
		bit         typed;
		click_res_t res;
	} dir_row_t;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            in_valid    = 1'b0;
	logic            mode        = MODE_LOAD;
	logic [CW-1:0]   left_edge   = '0;
	logic [CW-1:0]   bottom_edge = '0;
	logic [CW-1:0]   right_edge  = '0;
	logic [CW-1:0]   top_edge    = '0;
	logic [CW-1:0]   point_x     = '0;
	logic [CW-1:0]   point_y     = '0;
	logic            out_stall   = 1'b0;
	logic            in_stall;
	logic            out_valid;
	logic            hit;
	logic [ID_W-1:0] window_id;

	// Predicted window stack, bottom at index 0.
	win_t        stack_tbl [NWIN];
	int unsigned stack_depth = 0;

	click_res_t  pending_hits [$];
	int unsigned errors      = 0;
	int unsigned cycles      = 0;
	bit          calm        = 1'b0;
	bit          hold_req    = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	window_stack_hit_test_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.left_edge   (left_edge),
		.bottom_edge (bottom_edge),
		.right_edge  (right_edge),
		.top_edge    (top_edge),
		.point_x     (point_x),
		.point_y     (point_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.window_id   (window_id)
	);

	function automatic int unsigned pause_len();
		return calm ? 0 : $urandom_range(14, 0);
	endfunction

	function automatic wreq_t mk_load(int unsigned l, int unsigned b, int unsigned r,
			int unsigned t);
		wreq_t q;
		q.mode   = MODE_LOAD;
		q.left   = CW'(l);
		q.bottom = CW'(b);
		q.right  = CW'(r);
		q.top    = CW'(t);
		q.px     = CW'($urandom);
		q.py     = CW'($urandom);
		return q;
	endfunction

	function automatic wreq_t mk_click(int unsigned x, int unsigned y);
		wreq_t q;
		q.mode   = MODE_CLICK;
		q.left   = CW'($urandom);
		q.bottom = CW'($urandom);
		q.right  = CW'($urandom);
		q.top    = CW'($urandom);
		q.px     = CW'(x);
		q.py     = CW'(y);
		return q;
	endfunction

	// Mostly well-ordered rectangles of varied size; about one in eight comes out inverted.
	function automatic wreq_t rand_load();
		int unsigned x0, x1, y0, y1;
		x0 = $urandom_range(COORD_MAX, 0);
		y0 = $urandom_range(COORD_MAX, 0);
		x1 = ($urandom_range(3, 0) == 0) ? COORD_MAX : x0 + $urandom_range(1500, 0);
		y1 = ($urandom_range(3, 0) == 0) ? COORD_MAX : y0 + $urandom_range(1500, 0);
		if (x1 > COORD_MAX) x1 = COORD_MAX;
		if (y1 > COORD_MAX) y1 = COORD_MAX;
		if ($urandom_range(7, 0) == 0)
			return mk_load(x1, y0, x0, y1);
		return mk_load(x0, y0, x1, y1);
	endfunction

	// Applies one request to the predicted stack; returns 1 when a result is due.
	function automatic bit stack_apply(input wreq_t r, output click_res_t res);
		win_t moved;
		res.hit = 1'b0;
		res.id  = '0;
		if (r.mode == MODE_LOAD) begin
			if (stack_depth < NWIN) begin
				stack_tbl[stack_depth] = '{r.left, r.bottom, r.right, r.top, ID_W'(stack_depth + 1)};
				stack_depth++;
			end
			return 1'b0;
		end
		for (int j = int'(stack_depth) - 1; j >= 0; j--) begin
			if (r.px >= stack_tbl[j].left && r.px <= stack_tbl[j].right &&
					r.py >= stack_tbl[j].bottom && r.py <= stack_tbl[j].top) begin
				moved   = stack_tbl[j];
				res.hit = 1'b1;
				res.id  = moved.id;
				// Rotate to the top; the entries above shift down one place.
				for (int k = j; k + 1 < int'(stack_depth); k++)
					stack_tbl[k] = stack_tbl[k + 1];
				stack_tbl[stack_depth - 1] = moved;
				break;
			end
		end
		return 1'b1;
	endfunction

	task automatic offer(input wreq_t r, input bit typed, input click_res_t typed_res);
		int unsigned gap;
		click_res_t  pred;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= r.mode;
		left_edge   <= r.left;
		bottom_edge <= r.bottom;
		right_edge  <= r.right;
		top_edge    <= r.top;
		point_x     <= r.px;
		point_y     <= r.py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (stack_apply(r, pred))
			pending_hits.push_back(typed ? typed_res : pred);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		click_res_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected result: hit %0d window_id %0d", hit, window_id);
				errors++;
			end else begin
				exp_res = pending_hits.pop_front();
				if (hit !== exp_res.hit) begin
					$error("hit: expected %0d, actual %0d", exp_res.hit, hit);
					errors++;
				end
				if (window_id !== exp_res.id) begin
					$error("window_id: expected %0d, actual %0d", exp_res.id, window_id);
					errors++;
				end
			end
		end
	end

	// Result side: a random hold-off before each result, or one long hold when asked.
	initial begin
		int unsigned n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = pause_len();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin
		dir_row_t    rows [$];
		wreq_t       q;
		win_t        w;
		int unsigned clicks;
		int unsigned sel;
		click_res_t  none;
		none = '{1'b0, '0};

		rows.push_back('{mk_click(0, 0), 1'b1, '{1'b0, ID_W'(0)}});
		rows.push_back('{mk_load(0, 0, COORD_MAX, 0), 1'b0, none});
		rows.push_back('{mk_click(COORD_MAX, 0), 1'b1, '{1'b1, ID_W'(1)}});
		// Left edge past the right edge: this window can never be hit.
		rows.push_back('{mk_load(100, 0, 50, COORD_MAX), 1'b0, none});
		rows.push_back('{mk_click(75, 0), 1'b1, '{1'b1, ID_W'(1)}});
		rows.push_back('{mk_load(COORD_MAX, 0, COORD_MAX, COORD_MAX), 1'b0, none});
		rows.push_back('{mk_click(COORD_MAX, 0), 1'b1, '{1'b1, ID_W'(3)}});
		rows.push_back('{mk_click(0, 0), 1'b1, '{1'b1, ID_W'(1)}});
		rows.push_back('{mk_click(COORD_MAX, 0), 1'b1, '{1'b1, ID_W'(1)}});
		rows.push_back('{mk_click(COORD_MAX, COORD_MAX), 1'b1, '{1'b1, ID_W'(3)}});
		rows.push_back('{mk_load(10, 20, 30, 40), 1'b0, none});
		rows.push_back('{mk_click(10, 20), 1'b0, none});
		rows.push_back('{mk_click(31, 40), 1'b0, none});
		// Bottom edge above the top edge is inverted as well.
		rows.push_back('{mk_load(200, 300, 400, 100), 1'b0, none});
		for (int i = 0; i < NWIN - 5; i++)
			rows.push_back('{rand_load(), 1'b0, none});
		// The stack is full now, so this load is dropped without a result.
		rows.push_back('{mk_load(0, 0, COORD_MAX, COORD_MAX), 1'b0, none});
		rows.push_back('{mk_click(2048, 3000), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer(rows[i].req, rows[i].typed, rows[i].res);

		clicks = 0;
		while (clicks < RANDOM_CLICKS) begin
			if (clicks % 100 == 0)
				calm = ($urandom_range(3, 0) == 0);
			if (clicks == 500) begin
				calm     = 1'b1;
				hold_req = 1'b1;
			end
			if (clicks == 1000) begin
				in_valid <= 1'b0;
				while (pending_hits.size() != 0) @(posedge clk);
			end
			sel = $urandom_range(9, 0);
			if (sel == 0) begin
				offer(rand_load(), 1'b0, none);
			end else begin
				q = mk_click($urandom, $urandom);
				w = stack_tbl[$urandom_range(stack_depth - 1, 0)];
				if (sel <= 7 && w.left <= w.right && w.bottom <= w.top) begin
					if ($urandom_range(3, 0) == 0) begin
						q.px = $urandom_range(1, 0) ? w.left : w.right;
						q.py = $urandom_range(1, 0) ? w.bottom : w.top;
					end else begin
						q.px = CW'($urandom_range(w.right, w.left));
						q.py = CW'($urandom_range(w.top, w.bottom));
					end
				end
				offer(q, 1'b0, none);
				clicks++;
			end
		end
		in_valid <= 1'b0;

		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
